// ===== sv/wsp_pkg.sv =====
// Shared types, constants and helpers for the world-to-screen projection core.
// No dependencies; imported by the core, its divider and its checker.
package wsp_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned DIM_W         = 14;
  localparam int unsigned CFG_W         = 64;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_MAT_REGS  = 6;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_01 = 3'd0,
    REG_ROW0_23 = 3'd1,
    REG_ROW1_01 = 3'd2,
    REG_ROW1_23 = 3'd3,
    REG_ROW3_01 = 3'd4,
    REG_ROW3_23 = 3'd5,
    REG_WIDTH   = 3'd6,
    REG_HEIGHT  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] world_x;
    logic signed [WORD_W-1:0] world_y;
    logic signed [WORD_W-1:0] world_z;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] screen_x;
    logic signed [WORD_W-1:0] screen_y;
    logic                     behind_camera;
  } out_t;

  // saturate a wide signed value to one word
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat_word = WORD_W'(hi);
    end else if (v < lo) begin
      sat_word = WORD_W'(lo);
    end else begin
      sat_word = WORD_W'(v);
    end
  endfunction

endpackage

// ===== sv/wsp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Uses wsp_pkg for the word width; instantiated twice by the projection core.
module wsp_div #(
  parameter int unsigned DW = 48
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [DW-1:0]                num_i,
  input  logic [wsp_pkg::WORD_W-1:0]   den_i,
  output logic [DW-1:0]                quo_o
);
  import wsp_pkg::*;

  logic [DW-1:0]     num_q [DW];
  logic [WORD_W-1:0] den_q [DW];
  logic [WORD_W:0]   rem_q [DW];
  logic [DW-1:0]     quo_q [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DW-1:0]     num_in;
    logic [WORD_W-1:0] den_in;
    logic [WORD_W:0]   rem_in;
    logic [DW-1:0]     quo_in;
    logic [WORD_W:0]   trial;
    logic [WORD_W+1:0] diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = '0;
      assign quo_in = '0;
    end else begin : g_next
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = {rem_in[WORD_W-1:0], num_in[DW-1-k]};
    assign diff  = {1'b0, trial} - {2'b00, den_in};
    assign ge    = ~diff[WORD_W+1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k] <= num_in;
        den_q[k] <= den_in;
        rem_q[k] <= ge ? diff[WORD_W:0] : trial;
        quo_q[k] <= {quo_in[DW-2:0], ge};
      end
    end
  end

  assign quo_o = quo_q[DW-1];

endmodule

// ===== sv/world_to_screen_projection_core.sv =====
// World-to-screen projection core: matrix rows, perspective divide, viewport map.
// Depends on wsp_pkg and wsp_div.
//
// Takes one world point per transfer and returns one screen point per transfer,
// all in signed fixed point with FRAC_BITS fraction bits. Fully pipelined: a new
// point is taken every cycle the output side is not stalled. The two dividers
// resolve one quotient bit per stage over 32 + FRAC_BITS stages. A stall on the
// output freezes the whole pipe and shows up on in_stall_o in the same cycle.
// Matrix and viewport registers are written through the cfg port, which is
// always ready; write them only while the pipe is empty. Indexes past the
// list are ignored.
module world_to_screen_projection_core #(
  parameter int unsigned FRAC_BITS = wsp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wsp_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  wsp_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output wsp_pkg::out_t                   out_data_o
);
  import wsp_pkg::*;

  localparam int unsigned DW = WORD_W + FRAC_BITS;

  typedef struct packed {
    logic                     behind;
    logic signed [WORD_W-1:0] big_x;
    logic signed [WORD_W-1:0] big_y;
    logic                     neg_x;
    logic                     neg_y;
  } side_t;

  // ---- configuration registers ----
  logic [CFG_W-1:0] mat_q [NUM_MAT_REGS];
  logic [DIM_W-1:0] width_q, height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MAT_REGS; i++) mat_q[i] <= '0;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_ROW0_01: mat_q[0] <= cfg_data_i;
        REG_ROW0_23: mat_q[1] <= cfg_data_i;
        REG_ROW1_01: mat_q[2] <= cfg_data_i;
        REG_ROW1_23: mat_q[3] <= cfg_data_i;
        REG_ROW3_01: mat_q[4] <= cfg_data_i;
        REG_ROW3_23: mat_q[5] <= cfg_data_i;
        REG_WIDTH:   width_q  <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT:  height_q <= cfg_data_i[DIM_W-1:0];
        default:     ;
      endcase
    end
  end

  // whole pipe advances together unless the output register is held
  logic en;
  logic out_valid_q;
  assign en         = ~(out_valid_q & out_stall_i);
  assign in_stall_o = ~en;

  // ---- stage 1: nine products, floored to FRAC_BITS ----
  logic               v1_q;
  logic signed [63:0] prod_q [3][3];
  logic signed [WORD_W-1:0] trans_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[r][0] <= ($signed(mat_q[2*r][WORD_W-1:0]) * in_data_i.world_x) >>> FRAC_BITS;
        prod_q[r][1] <= ($signed(mat_q[2*r][CFG_W-1:WORD_W]) * in_data_i.world_y)
                        >>> FRAC_BITS;
        prod_q[r][2] <= ($signed(mat_q[2*r+1][WORD_W-1:0]) * in_data_i.world_z)
                        >>> FRAC_BITS;
        trans_q[r]   <= $signed(mat_q[2*r+1][CFG_W-1:WORD_W]);
      end
    end
  end

  // ---- stage 2: row sums, saturated (clip x, clip y, w) ----
  logic                     v2_q;
  logic signed [WORD_W-1:0] clip_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        clip_q[r] <= sat_word(prod_q[r][0] + prod_q[r][1] + prod_q[r][2]
                              + 64'(trans_q[r]));
      end
    end
  end

  // ---- stage 3: threshold, large-scale path, divider setup ----
  logic                     v3_q;
  side_t                    side3_q;
  logic [DW-1:0]            num_x_q, num_y_q;
  logic [WORD_W-1:0]        den_q;
  logic signed [WORD_W+10:0] w_k;
  logic                     behind_d;
  logic signed [WORD_W-1:0] cx, cy;
  logic [WORD_W-1:0]        mag_x, mag_y;

  assign cx       = clip_q[0];
  assign cy       = clip_q[1];
  assign w_k      = (WORD_W+11)'(clip_q[2]) * $signed(11'sd1000);
  assign behind_d = w_k < $signed((WORD_W+11)'(1) <<< FRAC_BITS);
  assign mag_x    = cx[WORD_W-1] ? WORD_W'(-cx) : WORD_W'(cx);
  assign mag_y    = cy[WORD_W-1] ? WORD_W'(-cy) : WORD_W'(cy);

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q.behind <= behind_d;
      side3_q.big_x  <= sat_word(64'(cx) * 64'sd100000);
      side3_q.big_y  <= sat_word(64'(cy) * 64'sd100000);
      side3_q.neg_x  <= cx[WORD_W-1];
      side3_q.neg_y  <= cy[WORD_W-1];
      num_x_q        <= {mag_x, FRAC_BITS'(0)};
      num_y_q        <= {mag_y, FRAC_BITS'(0)};
      den_q          <= clip_q[2];
    end
  end

  // ---- divide pipe with matching sideband delay ----
  logic [DW-1:0] quo_x, quo_y;

  wsp_div #(.DW(DW)) u_div_x (
    .clk_i (clk_i), .en_i (en), .num_i (num_x_q), .den_i (den_q), .quo_o (quo_x)
  );
  wsp_div #(.DW(DW)) u_div_y (
    .clk_i (clk_i), .en_i (en), .num_i (num_y_q), .den_i (den_q), .quo_o (quo_y)
  );

  logic  dv_q   [DW];
  side_t side_q [DW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side3_q;
      for (int k = 1; k < DW; k++) side_q[k] <= side_q[k-1];
    end
  end

  // ---- stage Q: sign, saturate, pick path ----
  logic                     vq_q;
  logic signed [WORD_W-1:0] xv_q, yv_q;
  logic                     behind_q_q;
  logic signed [63:0]       qx, qy;
  side_t                    sd;

  assign sd = side_q[DW-1];
  assign qx = sd.neg_x ? -$signed(64'(quo_x)) : $signed(64'(quo_x));
  assign qy = sd.neg_y ? -$signed(64'(quo_y)) : $signed(64'(quo_y));

  always_ff @(posedge clk_i) begin
    if (en) begin
      xv_q       <= sd.behind ? sd.big_x : sat_word(qx);
      yv_q       <= sd.behind ? sd.big_y : sat_word(qy);
      behind_q_q <= sd.behind;
    end
  end

  // ---- stage M: scale by viewport size ----
  logic                      vm_q;
  logic signed [WORD_W+DIM_W:0] px_q, py_q;
  logic                      behind_m_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q       <= (WORD_W+DIM_W+1)'(xv_q) * $signed({1'b0, width_q});
      py_q       <= (WORD_W+DIM_W+1)'(yv_q) * $signed({1'b0, height_q});
      behind_m_q <= behind_q_q;
    end
  end

  // ---- output stage: center offset, half pixel, saturate ----
  logic signed [63:0] ctr_x, ctr_y, half, sx, sy;
  out_t               out_q;

  assign ctr_x = $signed(64'(width_q  >> 1)) <<< FRAC_BITS;
  assign ctr_y = $signed(64'(height_q >> 1)) <<< FRAC_BITS;
  assign half  = 64'sd1 <<< (FRAC_BITS - 1);
  assign sx    = ctr_x + 64'(px_q >>> 1) + half;
  assign sy    = ctr_y - (64'(py_q >>> 1) + half);

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.screen_x      <= sat_word(sx);
      out_q.screen_y      <= sat_word(sy);
      out_q.behind_camera <= behind_m_q;
    end
  end

  // ---- valid chain ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      for (int k = 0; k < DW; k++) dv_q[k] <= 1'b0;
      vq_q        <= 1'b0;
      vm_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      dv_q[0] <= v3_q;
      for (int k = 1; k < DW; k++) dv_q[k] <= dv_q[k-1];
      vq_q        <= dv_q[DW-1];
      vm_q        <= vq_q;
      out_valid_q <= vm_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/wsp_chk.sv =====
// Port-level checker for the projection core, bound into every core instance.
// Depends on wsp_pkg.
module wsp_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input wsp_pkg::out_t out_data_o
);
  import wsp_pkg::*;

  // input side stalls exactly when a held result blocks the pipe
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not track output back-pressure");

  // held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

  // input side stalls only while a result is pending at the output
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("stall raised without a pending result");

endmodule

bind world_to_screen_projection_core wsp_chk u_wsp_chk (.*);

// ===== sim/world_to_screen_projection_core_tb.sv =====
// Self-checking testbench for world_to_screen_projection_core.
// Depends on wsp_pkg and the core RTL; a built-in predictor checks every transfer.
module world_to_screen_projection_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsp_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam longint ONE_Q = longint'(1) << FB;
  // Drain wait after the last expected result; a bit above the pipe depth.
  localparam int DRAIN_CYC = 38 + FB + 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  world_to_screen_projection_core #(.FRAC_BITS(FB)) i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i, .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the register file.
  logic [CFG_W-1:0] mat_regs[NUM_MAT_REGS];
  logic [DIM_W-1:0] view_w = WIDTH_RST;
  logic [DIM_W-1:0] view_h = HEIGHT_RST;

  in_t  point_q[$];     // points waiting to be offered
  out_t screen_q[$];    // projected points waiting at the output
  int   sender_idle = 0;
  int   recv_idle = 0;
  int   err_cnt = 0;

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // One matrix row (two registers) dotted with the point, plus translation.
  function automatic longint mat_row(int r, longint px, longint py, longint pz);
    longint c0, c1, c2, c3;
    c0 = longint'($signed(mat_regs[r][31:0]));
    c1 = longint'($signed(mat_regs[r][63:32]));
    c2 = longint'($signed(mat_regs[r+1][31:0]));
    c3 = longint'($signed(mat_regs[r+1][63:32]));
    return clamp_word(((c0 * px) >>> FB) + ((c1 * py) >>> FB) + ((c2 * pz) >>> FB) + c3);
  endfunction

  function automatic out_t project_point(in_t p);
    longint px, py, pz, cx, cy, w, wd, ht, sx, sy;
    out_t r;
    px = longint'(p.world_x);
    py = longint'(p.world_y);
    pz = longint'(p.world_z);
    cx = mat_row(0, px, py, pz);
    cy = mat_row(2, px, py, pz);
    w  = mat_row(4, px, py, pz);
    wd = longint'(view_w);
    ht = longint'(view_h);
    r.behind_camera = (w * 1000) < ONE_Q;
    if (r.behind_camera) begin
      cx = clamp_word(cx * 100000);
      cy = clamp_word(cy * 100000);
    end else begin
      cx = clamp_word((cx * ONE_Q) / w);   // SV division truncates toward zero
      cy = clamp_word((cy * ONE_Q) / w);
    end
    sx = (wd >>> 1) * ONE_Q + ((cx * wd) >>> 1) + (ONE_Q >>> 1);
    sy = (ht >>> 1) * ONE_Q - (((cy * ht) >>> 1) + (ONE_Q >>> 1));
    r.screen_x = 32'(clamp_word(sx));
    r.screen_y = 32'(clamp_word(sy));
    return r;
  endfunction

  // Driver: accepts, predicts, then offers the next point or idles.
  always @(posedge clk_i) begin
    logic nxt_valid;
    nxt_valid = in_valid_i;
    if (in_valid_i && !in_stall_o) begin
      screen_q.push_back(project_point(in_data_i));
      nxt_valid = 1'b0;
    end
    if (!nxt_valid && point_q.size() > 0 && rst_ni &&
        $urandom_range(99) >= sender_idle) begin
      in_data_i <= point_q.pop_front();
      nxt_valid = 1'b1;
    end
    in_valid_i <= nxt_valid;
  end

  // Monitor: checks each output transfer, then randomizes backpressure.
  always @(posedge clk_i) begin
    out_t exp_pt;
    if (out_valid_o && !out_stall_i) begin
      if (screen_q.size() == 0) begin
        $error("output transfer with no point pending");
        err_cnt++;
      end else begin
        exp_pt = screen_q.pop_front();
        if (out_data_o.screen_x !== exp_pt.screen_x) begin
          $error("screen_x exp %0d got %0d", exp_pt.screen_x, out_data_o.screen_x);
          err_cnt++;
        end
        if (out_data_o.screen_y !== exp_pt.screen_y) begin
          $error("screen_y exp %0d got %0d", exp_pt.screen_y, out_data_o.screen_y);
          err_cnt++;
        end
        if (out_data_o.behind_camera !== exp_pt.behind_camera) begin
          $error("behind_camera exp %0b got %0b", exp_pt.behind_camera,
                 out_data_o.behind_camera);
          err_cnt++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle);
  end

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < NUM_MAT_REGS) mat_regs[idx] = d;
    else if (idx == REG_WIDTH) view_w = d[DIM_W-1:0];
    else view_h = d[DIM_W-1:0];
  endtask

  // Hold off until the pipe is empty, then past its depth, then confirm that
  // no point was picked up by the driver in the same edge as the first check.
  task automatic drain();
    while (point_q.size() > 0 || in_valid_i || screen_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    while (point_q.size() > 0 || in_valid_i || screen_q.size() > 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] q16(int v);
    return 32'(v * 65536);
  endfunction

  // Coordinates: mostly modest values, sometimes full range or the rails.
  function automatic logic [31:0] rand_word(int scale_bits);
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($urandom_range(0, 1 << scale_bits)) - 32'(1 << (scale_bits - 1));
    endcase
  endfunction

  // Random camera; usually keeps w positive so the divide path is exercised.
  task automatic load_camera();
    for (int r = 0; r < 4; r++) begin
      write_reg(cfg_reg_e'(r), $urandom_range(7) == 0 ? {$urandom, $urandom} :
                {rand_word(19), rand_word(19)});
    end
    if ($urandom_range(3) == 0) begin
      write_reg(REG_ROW3_01, {$urandom, $urandom});
      write_reg(REG_ROW3_23, {$urandom, $urandom});
    end else begin
      write_reg(REG_ROW3_01, {rand_word(13), rand_word(13)});
      write_reg(REG_ROW3_23, {32'($urandom_range(32, 1 << 20)), rand_word(16)});
    end
  endtask

  task automatic queue_random(int n);
    in_t p;
    for (int i = 0; i < n; i++) begin
      p.world_x = rand_word(20);
      p.world_y = rand_word(20);
      p.world_z = rand_word(20);
      point_q.push_back(p);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_MAT_REGS; i++) mat_regs[i] = '0;
    sender_idle = 13;
    recv_idle = 62;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: w is zero, so everything lands behind the camera.
    point_q.push_back('{32'h0, 32'h0, 32'h0});
    point_q.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    point_q.push_back('{32'h80000000, 32'h80000000, 32'h80000000});
    point_q.push_back('{32'hffffffff, 32'h00000001, 32'h55555555});
    drain();

    // Plain camera: clip x = x, clip y = y, w = z.
    write_reg(REG_ROW0_01, {32'h0, q16(1)});
    write_reg(REG_ROW0_23, '0);
    write_reg(REG_ROW1_01, {q16(1), 32'h0});
    write_reg(REG_ROW1_23, '0);
    write_reg(REG_ROW3_01, '0);
    write_reg(REG_ROW3_23, {32'h0, q16(1)});
    point_q.push_back('{q16(3), q16(-2), 32'd66});         // just at threshold
    point_q.push_back('{q16(3), q16(-2), 32'd65});         // just below
    point_q.push_back('{q16(1), q16(1), q16(1)});
    point_q.push_back('{q16(-1), q16(-1), q16(-4)});       // w negative
    point_q.push_back('{32'h7fffffff, 32'h80000000, 32'd66}); // divide saturates
    point_q.push_back('{32'h80000000, 32'h7fffffff, 32'h0});  // scale saturates
    point_q.push_back('{q16(100), q16(-100), 32'h7fffffff});
    point_q.push_back('{32'h0, 32'h0, 32'h80000000});
    drain();

    // Viewport extremes, including zero and all-ones sizes.
    write_reg(REG_WIDTH, 64'h0);
    write_reg(REG_HEIGHT, 64'hffffffffffffffff);
    point_q.push_back('{q16(1), q16(1), q16(2)});
    point_q.push_back('{32'h7fffffff, 32'h80000000, q16(1)});
    drain();
    write_reg(REG_WIDTH, 64'd8192);
    write_reg(REG_HEIGHT, 64'd1);
    point_q.push_back('{q16(-1), q16(1), q16(1)});
    point_q.push_back('{32'h80000000, 32'h7fffffff, 32'd65});
    drain();

    // Random phases; the drains between them also pause the sender fully.
    for (int ph = 0; ph < 6; ph++) begin
      sender_idle = (ph < 2) ? 13 : (ph < 4) ? 62 : 0;
      recv_idle   = (ph < 2) ? 62 : (ph < 4) ? 13 : 0;
      load_camera();
      write_reg(REG_WIDTH, (ph == 5) ? 64'h3fff : {$urandom, 18'($urandom), 14'($urandom_range(1, 8192))});
      write_reg(REG_HEIGHT, (ph == 5) ? 64'd0 : {$urandom, 18'($urandom), 14'($urandom_range(1, 8192))});
      queue_random(190);
      drain();
    end

    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== world_to_screen_projection_core.f =====
sv/wsp_pkg.sv
sv/wsp_div.sv
sv/world_to_screen_projection_core.sv
sv/wsp_chk.sv
sim/world_to_screen_projection_core_tb.sv
